@@ rtl/top_k_magnitude_selector_top_defines.svh @@
// ----------------------------------------------------------------------------
// top_k_magnitude_selector_top_defines.svh
// Assertion macros shared by the top-k magnitude selector RTL.
// ----------------------------------------------------------------------------
`ifndef TOP_K_MAGNITUDE_SELECTOR_TOP_DEFINES_SVH
`define TOP_K_MAGNITUDE_SELECTOR_TOP_DEFINES_SVH

// Condition that must hold at every clock edge out of reset
`define TKMS_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Consequent that must hold in the same cycle as the antecedent
`define TKMS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

@@ rtl/tkms_pkg.sv @@
// ----------------------------------------------------------------------------
// tkms_pkg
// Widths, codes, controller/datapath interface types and the magnitude
// function of the top-k magnitude selector.
// ----------------------------------------------------------------------------
package tkms_pkg;

  // Field widths
  localparam int COEF_W = 32;
  localparam int IDX_W  = 24;
  localparam int KEEP_W = 11;
  localparam int MAG_W  = 31;

  // Parameter defaults
  localparam int CAPACITY_DEF   = 1024;
  localparam int INDEX_BITS_DEF = 24;

  // Register file
  localparam int                PADDR_W         = 3;
  localparam int                PDATA_W         = 32;
  localparam logic [KEEP_W-1:0] KEEP_RESET      = 11'd1000;
  localparam logic              REG_KEEP_COUNT  = 1'b0;   // word index in paddr[2]

  // Request kinds
  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  // Datapath commands
  typedef enum logic [3:0] {
    DP_NONE,
    DP_LOAD,       // latch request
    DP_INS,        // open slot at the tail, occupancy + 1
    DP_ROOT_RD,    // read root
    DP_POS_ROOT,   // start sift down from the root with the new entry
    DP_POP_RD,     // read root and last slot
    DP_POP_OUT,    // emit root, last entry becomes the mover
    DP_EMPTY_OUT,  // emit empty marker
    DP_UP_RD,      // read parent
    DP_UP_SWAP,    // parent moves down into the hole
    DP_DN_RD,      // read both children
    DP_DN_SWAP,    // smaller child moves up into the hole
    DP_PLACE       // write mover into the hole
  } dp_op_t;

  // Datapath status
  typedef struct packed {
    logic is_pop;
    logic occ_zero;
    logic limit_zero;
    logic has_room;
    logic out_free;
    logic replace;
    logic at_root;
    logic up_swap;
    logic dn_leaf;
    logic dn_swap;
  } dp_status_t;

  // |c| as 31-bit unsigned, most negative code saturates
  function automatic logic [MAG_W-1:0] coef_mag(input logic [COEF_W-1:0] c);
    logic [COEF_W-1:0] neg;
    neg = -c;
    if (c == {1'b1, {MAG_W{1'b0}}}) begin
      return {MAG_W{1'b1}};
    end else if (c[COEF_W-1]) begin
      return neg[MAG_W-1:0];
    end else begin
      return c[MAG_W-1:0];
    end
  endfunction

endpackage

@@ rtl/tkms_ctrl.sv @@
// ----------------------------------------------------------------------------
// tkms_ctrl
// Sequencer for push, pop and the heap sift walks; drives datapath commands.
// ----------------------------------------------------------------------------
module tkms_ctrl
  import tkms_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t st,
  output dp_op_t     op
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_UP_RD,
    S_UP_CMP,
    S_ROOT_CMP,
    S_POP_CMP,
    S_DN_RD,
    S_DN_CMP
  } state_t;

  state_t state;
  state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and command
  always_comb begin
    state_next = state;
    op         = DP_NONE;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          op         = DP_LOAD;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (!st.is_pop) begin
          if (st.limit_zero) begin
            state_next = S_IDLE;
          end else if (st.has_room) begin
            op         = DP_INS;
            state_next = S_UP_RD;
          end else begin
            op         = DP_ROOT_RD;
            state_next = S_ROOT_CMP;
          end
        end else if (st.occ_zero) begin
          if (st.out_free) begin
            op         = DP_EMPTY_OUT;
            state_next = S_IDLE;
          end
        end else begin
          op         = DP_POP_RD;
          state_next = S_POP_CMP;
        end
      end
      S_UP_RD: begin
        if (st.at_root) begin
          op         = DP_PLACE;
          state_next = S_IDLE;
        end else begin
          op         = DP_UP_RD;
          state_next = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        if (st.up_swap) begin
          op         = DP_UP_SWAP;
          state_next = S_UP_RD;
        end else begin
          op         = DP_PLACE;
          state_next = S_IDLE;
        end
      end
      S_ROOT_CMP: begin
        if (st.replace) begin
          op         = DP_POS_ROOT;
          state_next = S_DN_RD;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_POP_CMP: begin
        // hold until the result register is free
        if (st.out_free) begin
          op         = DP_POP_OUT;
          state_next = S_DN_RD;
        end
      end
      S_DN_RD: begin
        if (st.dn_leaf) begin
          op         = DP_PLACE;
          state_next = S_IDLE;
        end else begin
          op         = DP_DN_RD;
          state_next = S_DN_CMP;
        end
      end
      S_DN_CMP: begin
        if (st.dn_swap) begin
          op         = DP_DN_SWAP;
          state_next = S_DN_RD;
        end else begin
          op         = DP_PLACE;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/tkms_dp.sv @@
// ----------------------------------------------------------------------------
// tkms_dp
// Heap memory, mover and hole registers, occupancy and the result register.
// ----------------------------------------------------------------------------
`include "top_k_magnitude_selector_top_defines.svh"

module tkms_dp
  import tkms_pkg::*;
#(
  parameter int CAPACITY   = CAPACITY_DEF,
  parameter int INDEX_BITS = INDEX_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_cmd,
  input  logic [COEF_W-1:0] in_coef,
  input  logic [IDX_W-1:0]  in_idx,
  input  logic [KEEP_W-1:0] keep_count,
  input  dp_op_t            op,
  output dp_status_t        st,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [COEF_W-1:0] out_coef,
  output logic [IDX_W-1:0]  out_idx,
  output logic              out_empty
);

  localparam int AW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int OW  = $clog2(CAPACITY + 1);
  localparam int PW  = AW + 2;
  localparam int CW  = (OW > KEEP_W) ? OW : KEEP_W;
  localparam int ISW = (INDEX_BITS < IDX_W) ? INDEX_BITS : IDX_W;
  localparam int EW  = COEF_W + ISW;

  // Heap store: {coefficient, index}
  logic [EW-1:0]     mem [CAPACITY];
  logic [EW-1:0]     rd0;
  logic [EW-1:0]     rd1;
  logic [AW-1:0]     ra0;
  logic [AW-1:0]     ra1;
  logic              re;
  logic              we;
  logic [AW-1:0]     wa;
  logic [EW-1:0]     wd;

  // Control state
  logic [OW-1:0]     occ;
  logic [AW-1:0]     pos;
  logic              is_pop;

  // Mover entry
  logic [COEF_W-1:0] mv_coef;
  logic [ISW-1:0]    mv_idx;
  logic [MAG_W-1:0]  mv_mag;

  // Derived
  logic [MAG_W-1:0]  mag0;
  logic [MAG_W-1:0]  mag1;
  logic [PW-1:0]     left_w;
  logic [PW-1:0]     right_w;
  logic [PW-1:0]     occ_w;
  logic              right_ok;
  logic              pick_right;
  logic [EW-1:0]     pick_ent;
  logic [MAG_W-1:0]  pick_mag;
  logic [AW-1:0]     pick_pos;
  logic [AW-1:0]     parent;
  logic [OW-1:0]     occ_m1;
  logic [CW-1:0]     cap_c;
  logic [CW-1:0]     keep_c;
  logic [CW-1:0]     limit_c;

  assign mag0       = coef_mag(rd0[EW-1 -: COEF_W]);
  assign mag1       = coef_mag(rd1[EW-1 -: COEF_W]);
  assign left_w     = (PW'(pos) << 1) + PW'(1);
  assign right_w    = left_w + PW'(1);
  assign occ_w      = PW'(occ);
  assign right_ok   = right_w < occ_w;
  assign pick_right = right_ok && (mag1 < mag0);
  assign pick_ent   = pick_right ? rd1 : rd0;
  assign pick_mag   = pick_right ? mag1 : mag0;
  assign pick_pos   = pick_right ? right_w[AW-1:0] : left_w[AW-1:0];
  assign parent     = (pos - AW'(1)) >> 1;
  assign occ_m1     = occ - OW'(1);

  // Retention limit, saturated at the store size
  assign cap_c   = CW'(CAPACITY);
  assign keep_c  = CW'(keep_count);
  assign limit_c = (keep_c > cap_c) ? cap_c : keep_c;

  // Status to the controller
  always_comb begin
    st.is_pop     = is_pop;
    st.occ_zero   = (occ == '0);
    st.limit_zero = (keep_count == '0);
    st.has_room   = CW'(occ) < limit_c;
    st.out_free   = !out_valid || out_ready;
    st.replace    = mv_mag > mag0;
    st.at_root    = (pos == '0);
    st.up_swap    = mag0 > mv_mag;
    st.dn_leaf    = left_w >= occ_w;
    st.dn_swap    = pick_mag < mv_mag;
  end

  // Memory port selection
  always_comb begin
    re  = 1'b0;
    we  = 1'b0;
    ra0 = left_w[AW-1:0];
    ra1 = right_ok ? right_w[AW-1:0] : left_w[AW-1:0];
    wa  = pos;
    wd  = {mv_coef, mv_idx};
    case (op)
      DP_ROOT_RD: begin
        re  = 1'b1;
        ra0 = '0;
      end
      DP_POP_RD: begin
        re  = 1'b1;
        ra0 = '0;
        ra1 = occ_m1[AW-1:0];
      end
      DP_UP_RD: begin
        re  = 1'b1;
        ra0 = parent;
      end
      DP_DN_RD: begin
        re = 1'b1;
      end
      DP_UP_SWAP: begin
        we = 1'b1;
        wd = rd0;
      end
      DP_DN_SWAP: begin
        we = 1'b1;
        wd = pick_ent;
      end
      DP_PLACE: begin
        we = 1'b1;
      end
      default: begin
        re = 1'b0;
      end
    endcase
  end

  // Heap memory, registered reads
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rd0 <= mem[ra0];
      rd1 <= mem[ra1];
    end
  end

  // Occupancy and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      occ       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (op)
        DP_INS: begin
          occ <= occ + OW'(1);
        end
        DP_POP_OUT: begin
          occ       <= occ_m1;
          out_valid <= 1'b1;
        end
        DP_EMPTY_OUT: begin
          out_valid <= 1'b1;
        end
        default: begin
          occ <= occ;
        end
      endcase
    end
  end

  // Mover, hole position and result payload
  always_ff @(posedge clk) begin
    case (op)
      DP_LOAD: begin
        is_pop  <= (in_cmd == CMD_POP);
        mv_coef <= in_coef;
        mv_idx  <= in_idx[ISW-1:0];
        mv_mag  <= coef_mag(in_coef);
      end
      DP_INS: begin
        pos <= occ[AW-1:0];
      end
      DP_POS_ROOT: begin
        pos <= '0;
      end
      DP_POP_OUT: begin
        out_coef  <= rd0[EW-1 -: COEF_W];
        out_idx   <= IDX_W'(rd0[ISW-1:0]);
        out_empty <= 1'b0;
        mv_coef   <= rd1[EW-1 -: COEF_W];
        mv_idx    <= rd1[ISW-1:0];
        mv_mag    <= mag1;
        pos       <= '0;
      end
      DP_EMPTY_OUT: begin
        out_coef  <= '0;
        out_idx   <= '0;
        out_empty <= 1'b1;
      end
      DP_UP_SWAP: begin
        pos <= parent;
      end
      DP_DN_SWAP: begin
        pos <= pick_pos;
      end
      default: begin
        pos <= pos;
      end
    endcase
  end

  `TKMS_ASSERT(a_occ_bound, occ <= OW'(CAPACITY), "occupancy above capacity")
  `TKMS_ASSERT_IMPL(a_occ_step, occ != $past(occ), (occ == $past(occ) + OW'(1)) || (occ == $past(occ) - OW'(1)), "occupancy moved by more than one")
  `TKMS_ASSERT_IMPL(a_empty_zero, out_valid && out_empty, (out_coef == '0) && (out_idx == '0), "empty result carries data")
  `TKMS_ASSERT_IMPL(a_no_overwrite, (op == DP_POP_OUT) || (op == DP_EMPTY_OUT), !out_valid || out_ready, "pending result overwritten")

endmodule

@@ rtl/top_k_magnitude_selector_top.sv @@
// ----------------------------------------------------------------------------
// top_k_magnitude_selector_top
// Keeps the keep_count largest-magnitude coefficients of a stream in a
// min-heap; a pop request returns and removes the smallest kept entry.
// ----------------------------------------------------------------------------
// One request is worked at a time. Each heap level an entry moves takes a
// registered read of the single heap memory, then a compare and a write.
// With L the number of levels moved (at most floor(log2(CAPACITY)), 10 at
// 1024 entries), a push that inserts sifts the new entry up L levels, and a
// push that replaces the root and a pop sift the moving entry down L levels;
// a push that is dropped moves no entry. A finished pop result sits in the
// output register while the next request is taken; a second pop waits for it
// to be drained, which adds its wait to that pop. keep_count must be written
// only while idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module top_k_magnitude_selector_top
  import tkms_pkg::*;
#(
  parameter int CAPACITY   = CAPACITY_DEF,
  parameter int INDEX_BITS = INDEX_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  // request stream
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [55:0]        s_tdata,   // [31:0] coefficient, [55:32] entry_index
  input  logic               s_tuser,   // [0] cmd
  // result stream
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [55:0]        m_tdata,   // [31:0] out_coefficient, [55:32] out_index
  output logic               m_tuser,   // [0] is_empty
  // register port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  logic [KEEP_W-1:0] keep_count;
  logic              reg_hit;
  dp_status_t        st;
  dp_op_t            op;
  logic [COEF_W-1:0] out_coef;
  logic [IDX_W-1:0]  out_idx;

  // Register port
  assign pready  = 1'b1;
  assign reg_hit = (paddr[2] == REG_KEEP_COUNT);
  assign prdata  = reg_hit ? PDATA_W'(keep_count) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      keep_count <= KEEP_RESET;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      keep_count <= pwdata[KEEP_W-1:0];
    end
  end

  // Controller
  tkms_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .st       (st),
    .op       (op)
  );

  // Datapath
  tkms_dp #(
    .CAPACITY   (CAPACITY),
    .INDEX_BITS (INDEX_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .in_cmd     (s_tuser),
    .in_coef    (s_tdata[COEF_W-1:0]),
    .in_idx     (s_tdata[COEF_W +: IDX_W]),
    .keep_count (keep_count),
    .op         (op),
    .st         (st),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_coef   (out_coef),
    .out_idx    (out_idx),
    .out_empty  (m_tuser)
  );

  assign m_tdata = {out_idx, out_coef};

endmodule
